### src/szrt_pkg.sv
package szrt_pkg;

   // Table geometry
   localparam int ZONE_SLOTS = 8;
   localparam int SLOT_W     = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
   localparam int INDEX_W    = 3;
   localparam int COORD_W    = 8;

   // Corner key offset, one column and one row
   localparam logic [2*COORD_W:0] CORNER_BIAS = 17'h00101;

   // Command codes
   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_MEMBER = 2'd3
   } cmd_type;

   // Response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd2;

   // One stored zone with its cut rectangle
   typedef struct packed {
      logic [COORD_W-1:0] x_lo;
      logic [COORD_W-1:0] y_lo;
      logic [COORD_W-1:0] x_size;
      logic [COORD_W-1:0] y_size;
      logic               cut_valid;
      logic [COORD_W-1:0] cut_x_lo;
      logic [COORD_W-1:0] cut_y_lo;
      logic [COORD_W-1:0] cut_x_hi;
      logic [COORD_W-1:0] cut_y_hi;
   } zone_entry_type;

   // Latched request transaction
   typedef struct packed {
      cmd_type            cmd;
      zone_entry_type     zone;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
   } req_type;

   // Write control towards the slot store
   typedef struct packed {
      logic              set;
      logic              clear;
      logic [SLOT_W-1:0] slot;
      zone_entry_type    data;
   } store_wr_type;

endpackage

### src/szrt_if.sv
interface szrt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] zone_x_lo;
   logic [7:0] zone_y_lo;
   logic [7:0] zone_x_size;
   logic [7:0] zone_y_size;
   logic       cut_valid;
   logic [7:0] cut_x_lo;
   logic [7:0] cut_y_lo;
   logic [7:0] cut_x_hi;
   logic [7:0] cut_y_hi;
   logic [7:0] point_x;
   logic [7:0] point_y;

   modport source (
      output valid, cmd, zone_x_lo, zone_y_lo, zone_x_size, zone_y_size, cut_valid,
             cut_x_lo, cut_y_lo, cut_x_hi, cut_y_hi, point_x, point_y,
      input  ready
   );
   modport sink (
      input  valid, cmd, zone_x_lo, zone_y_lo, zone_x_size, zone_y_size, cut_valid,
             cut_x_lo, cut_y_lo, cut_x_hi, cut_y_hi, point_x, point_y,
      output ready
   );
endinterface

interface szrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [2:0] zone_index;
   logic       belongs;

   modport source (output valid, status, zone_index, belongs, input ready);
   modport sink (input valid, status, zone_index, belongs, output ready);
endinterface

### src/szrt_slot_store.sv
module szrt_slot_store
   import szrt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  store_wr_type   wr,
   input  logic [SLOT_W-1:0] rd_slot,
   output zone_entry_type rd_entry,
   output logic           rd_occupied
);

   zone_entry_type          entries_ff [ZONE_SLOTS];
   logic [ZONE_SLOTS-1:0]   occupied_ff;
   logic [ZONE_SLOTS-1:0]   occupied_in;

   // Mark or release the addressed slot
   always_comb begin
      occupied_in = occupied_ff;
      if (wr.set) begin
         occupied_in[wr.slot] = 1'b1;
      end else if (wr.clear) begin
         occupied_in[wr.slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= '0;
      end else begin
         occupied_ff <= occupied_in;
      end
   end

   // Store zone fields on alloc
   always_ff @(posedge clock) begin
      if (wr.set) begin
         entries_ff[wr.slot] <= wr.data;
      end
   end

   assign rd_entry    = entries_ff[rd_slot];
   assign rd_occupied = occupied_ff[rd_slot];

endmodule

### src/szrt_match_unit.sv
module szrt_match_unit
   import szrt_pkg::*;
(
   input  req_type        req,
   input  zone_entry_type entry,
   input  logic           occupied,
   output logic           hit
);

   logic [COORD_W:0]     x_end;
   logic [COORD_W:0]     y_end;
   logic [2*COORD_W+1:0] corner_sum;
   logic [2*COORD_W:0]   corner_want;
   logic                 corner_hit;
   logic                 in_rect;
   logic                 in_cut;

   // Corner key: row carry spills into the column part
   assign x_end       = {1'b0, entry.x_lo} + {1'b0, entry.x_size};
   assign y_end       = {1'b0, entry.y_lo} + {1'b0, entry.y_size};
   assign corner_sum  = {1'b0, x_end, {COORD_W{1'b0}}} + {{(COORD_W+1){1'b0}}, y_end};
   assign corner_want = {1'b0, req.point_x, req.point_y} + CORNER_BIAS;
   assign corner_hit  = (corner_sum == {1'b0, corner_want});

   // Half-open zone, inclusive cut
   assign in_rect = (req.point_x >= entry.x_lo) && ({1'b0, req.point_x} < x_end) &&
                    (req.point_y >= entry.y_lo) && ({1'b0, req.point_y} < y_end);
   assign in_cut  = entry.cut_valid &&
                    (req.point_x >= entry.cut_x_lo) && (req.point_x <= entry.cut_x_hi) &&
                    (req.point_y >= entry.cut_y_lo) && (req.point_y <= entry.cut_y_hi);

   // Select the test for the command
   always_comb begin
      case (req.cmd)
         CMD_ALLOC:           hit = !occupied;
         CMD_FREE, CMD_FIND:  hit = occupied && corner_hit;
         CMD_MEMBER:          hit = occupied && !in_cut && in_rect;
         default:             hit = 1'b0;
      endcase
   end

endmodule

### src/secure_zone_region_table.sv
// The scan visits one slot a cycle through the shared match unit and stops at a hit
// or at the last slot. One transaction at a time: the next request is taken the cycle
// after the response is taken.
// Reset (synchronous, active high) clears all occupied bits and returns to idle;
// zone fields are kept but are never read from a free slot.
module secure_zone_region_table
   import szrt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   szrt_req_if.sink  req_bus,
   szrt_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   req_type           req_ff, req_in;
   logic [1:0]        status_ff, status_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic              belongs_ff, belongs_in;

   zone_entry_type    rd_entry;
   logic              rd_occupied;
   logic              hit;
   logic              last_slot;
   store_wr_type      wr;

   szrt_slot_store u_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .rd_slot     (slot_ff),
      .rd_entry    (rd_entry),
      .rd_occupied (rd_occupied)
   );

   szrt_match_unit u_match (
      .req      (req_ff),
      .entry    (rd_entry),
      .occupied (rd_occupied),
      .hit      (hit)
   );

   assign last_slot = (slot_ff == SLOT_W'(ZONE_SLOTS - 1));

   // Write or release the slot that matched
   always_comb begin
      wr.slot  = slot_ff;
      wr.data  = req_ff.zone;
      wr.set   = (state_ff == ST_SCAN) && hit && (req_ff.cmd == CMD_ALLOC);
      wr.clear = (state_ff == ST_SCAN) && hit && (req_ff.cmd == CMD_FREE);
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      req_in     = req_ff;
      status_in  = status_ff;
      index_in   = index_ff;
      belongs_in = belongs_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               req_in.cmd            = cmd_type'(req_bus.cmd);
               req_in.zone.x_lo      = req_bus.zone_x_lo;
               req_in.zone.y_lo      = req_bus.zone_y_lo;
               req_in.zone.x_size    = req_bus.zone_x_size;
               req_in.zone.y_size    = req_bus.zone_y_size;
               req_in.zone.cut_valid = req_bus.cut_valid;
               req_in.zone.cut_x_lo  = req_bus.cut_x_lo;
               req_in.zone.cut_y_lo  = req_bus.cut_y_lo;
               req_in.zone.cut_x_hi  = req_bus.cut_x_hi;
               req_in.zone.cut_y_hi  = req_bus.cut_y_hi;
               req_in.point_x        = req_bus.point_x;
               req_in.point_y        = req_bus.point_y;
               slot_in               = '0;
               state_in              = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               status_in  = STATUS_OK;
               index_in   = INDEX_W'(slot_ff);
               belongs_in = (req_ff.cmd == CMD_MEMBER);
               state_in   = ST_RESP;
            end else if (last_slot) begin
               index_in   = '0;
               belongs_in = 1'b0;
               case (req_ff.cmd)
                  CMD_ALLOC:          status_in = STATUS_FULL;
                  CMD_FREE, CMD_FIND: status_in = STATUS_NO_MATCH;
                  default:            status_in = STATUS_OK;
               endcase
               state_in = ST_RESP;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      req_ff     <= req_in;
      status_ff  <= status_in;
      index_ff   <= index_in;
      belongs_ff <= belongs_in;
   end

   // Drive the channels
   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = (state_ff == ST_RESP);
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.zone_index = index_ff;
   assign rsp_bus.belongs    = belongs_ff;

endmodule
